// ----- hdl/ccpr_pkg.sv -----
// package for the crc checked packet receiver: types, codes and crc step
package ccpr_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd1;

    localparam logic [7:0]  EXPECTED_ID_RESET = 8'd0;
    localparam logic [7:0]  CAPACITY_RESET    = 8'd255;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'h8408;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [1:0] STATUS_IDLE      = 2'd0;
    localparam logic [1:0] STATUS_RECEIVING = 2'd1;
    localparam logic [1:0] STATUS_FAILED    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ID      = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_LO  = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_FAILED  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       truncated;
        logic       done_res;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- hdl/ccpr_if.sv -----
// channel interfaces for the receiver: input bytes, results and configuration writes
interface ccpr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ccpr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       truncated;
    logic       done_res;

    modport source (output valid, output status, output payload_valid, output payload_byte,
                    output payload_index, output truncated, output done_res, input ready);
    modport sink   (input valid, input status, input payload_valid, input payload_byte,
                    input payload_index, input truncated, input done_res, output ready);
endinterface

interface ccpr_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/crc_checked_packet_receiver_top.sv -----
// top level of the crc checked packet receiver
// a result is registered and presented in the cycle after its input transaction is accepted
// one transaction per cycle unless the result register is full and not taken; the crc update of a byte is combinational
// input ready drops while the result register is full and not taken
// reset is synchronous and active low: phase idle, crc 0xffff, registers at reset values
module crc_checked_packet_receiver_top
    import ccpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccpr_in_if.sink     i_in,
    ccpr_out_if.source  o_out,
    ccpr_cfg_if.sink    i_cfg
);

    logic [7:0]  r_expected_id;
    logic [7:0]  r_capacity;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_header_id,   n_header_id;
    logic [7:0]  r_used_length, n_used_length;
    logic [7:0]  r_byte_count,  n_byte_count;
    logic [15:0] r_crc,         n_crc;
    logic [15:0] r_rx_crc,      n_rx_crc;
    logic        r_trunc,       n_trunc;

    logic        r_out_valid;
    t_result     r_out,         n_out;

    logic        in_accept;
    logic [7:0]  len_used;
    logic [7:0]  count_inc;
    logic [15:0] rx_crc_full;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    assign len_used    = (i_in.rx_byte > r_capacity) ? r_capacity : i_in.rx_byte;
    assign count_inc   = r_byte_count + 8'd1;
    assign rx_crc_full = {i_in.rx_byte, r_rx_crc[7:0]};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_in.op == OP_START) begin
            n_phase = PH_ID;
        end else begin
            unique case (r_phase)
                PH_ID:      n_phase = PH_LEN;
                PH_LEN: begin
                    if (r_header_id != r_expected_id) begin
                        n_phase = PH_FAILED;
                    end else if (len_used == 8'd0) begin
                        n_phase = PH_CRC_LO;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (count_inc >= r_used_length) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:  n_phase = PH_CRC_HI;
                PH_CRC_HI:  n_phase = (rx_crc_full == r_crc) ? PH_IDLE : PH_FAILED;
                default:    n_phase = r_phase;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_header_id   = r_header_id;
        n_used_length = r_used_length;
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_rx_crc      = r_rx_crc;
        n_trunc       = r_trunc;
        n_out         = '0;
        if (i_in.op == OP_START) begin
            n_header_id   = 8'd0;
            n_used_length = 8'd0;
            n_byte_count  = 8'd0;
            n_crc         = CRC_INIT;
            n_rx_crc      = 16'd0;
            n_trunc       = 1'b0;
        end else begin
            unique case (r_phase)
                PH_ID: begin
                    n_header_id = i_in.rx_byte;
                    // id folded into the crc here, length byte added next
                    n_crc       = crc_step(CRC_INIT, i_in.rx_byte);
                end
                PH_LEN: begin
                    if (r_header_id != r_expected_id) begin
                        n_out.done_res = 1'b1;
                    end else begin
                        n_trunc       = r_trunc || (i_in.rx_byte > r_capacity);
                        n_used_length = len_used;
                        n_crc         = crc_step(r_crc, len_used);
                        n_byte_count  = 8'd0;
                    end
                end
                PH_PAYLOAD: begin
                    n_out.payload_valid = 1'b1;
                    n_out.payload_byte  = i_in.rx_byte;
                    n_out.payload_index = r_byte_count;
                    n_crc               = crc_step(r_crc, i_in.rx_byte);
                    n_byte_count        = count_inc;
                end
                PH_CRC_LO: begin
                    n_rx_crc = {r_rx_crc[15:8], i_in.rx_byte};
                end
                PH_CRC_HI: begin
                    n_rx_crc       = rx_crc_full;
                    n_out.done_res = 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_out.truncated = n_trunc;
        if (n_phase == PH_IDLE) begin
            n_out.status = STATUS_IDLE;
        end else if (n_phase == PH_FAILED) begin
            n_out.status = STATUS_FAILED;
        end else begin
            n_out.status = STATUS_RECEIVING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= EXPECTED_ID_RESET;
            r_capacity    <= CAPACITY_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_EXPECTED_ID: r_expected_id <= i_cfg.data;
                REG_CAPACITY:    r_capacity    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_header_id   <= 8'd0;
            r_used_length <= 8'd0;
            r_byte_count  <= 8'd0;
            r_crc         <= CRC_INIT;
            r_rx_crc      <= 16'd0;
            r_trunc       <= 1'b0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_header_id   <= n_header_id;
            r_used_length <= n_used_length;
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_rx_crc      <= n_rx_crc;
            r_trunc       <= n_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.payload_index = r_out.payload_index;
    assign o_out.truncated     = r_out.truncated;
    assign o_out.done_res      = r_out.done_res;

`ifndef SYNTH
    a_start_enters_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in.op == OP_START |=> r_phase == PH_ID)
        else $error("start transaction did not enter id phase");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_byte_count < r_used_length)
        else $error("payload count reached used length inside payload phase");

    a_payload_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.payload_valid |-> r_out.status == STATUS_RECEIVING)
        else $error("payload byte reported outside reception");

    a_done_not_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.status != STATUS_RECEIVING)
        else $error("done reported while still receiving");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for the crc checked packet receiver: framed packets in, checked per-byte results out

module tb_top
    import ccpr_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic       op;
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_reg_write;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ccpr_in_if  in_ch ();
    ccpr_out_if out_ch ();
    ccpr_cfg_if cfg_ch ();

    logic                 in_valid  = 1'b0;
    logic                 in_op     = OP_START;
    logic [7:0]           in_byte   = 8'd0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_EXPECTED_ID;
    logic [7:0]           cfg_data  = 8'd0;

    assign in_ch.valid   = in_valid;
    assign in_ch.op      = in_op;
    assign in_ch.rx_byte = in_byte;
    assign out_ch.ready  = out_ready;
    assign cfg_ch.valid  = cfg_valid;
    assign cfg_ch.index  = cfg_index;
    assign cfg_ch.data   = cfg_data;

    crc_checked_packet_receiver_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    t_rx_item    pending_bytes[$];
    t_reg_write  pending_writes[$];
    t_result     expected_results[$];

    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned mismatches   = 0;
    int unsigned bytes_queued = 0;
    int unsigned quiet_cycles = 0;

    // stimulus-side view of the current register settings
    logic [7:0] stim_id  = EXPECTED_ID_RESET;
    logic [7:0] stim_cap = CAPACITY_RESET;

    // receiver model state
    logic [7:0]  cfg_expected_id = EXPECTED_ID_RESET;
    logic [7:0]  cfg_capacity    = CAPACITY_RESET;
    t_phase      rx_phase        = PH_IDLE;
    logic [7:0]  rx_id           = 8'd0;
    logic [7:0]  rx_len          = 8'd0;
    logic [7:0]  rx_count        = 8'd0;
    logic [15:0] rx_crc          = CRC_INIT;
    logic [15:0] rx_sent_crc     = 16'd0;
    logic        rx_trunc        = 1'b0;

    // bitwise reflected ccitt update, data bit fed in at the feedback point
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic predict_packet_byte(input t_rx_item it);
        t_result res;
        res = '0;
        if (it.op == OP_START) begin
            rx_phase    = PH_ID;
            rx_id       = 8'd0;
            rx_len      = 8'd0;
            rx_count    = 8'd0;
            rx_crc      = CRC_INIT;
            rx_sent_crc = 16'd0;
            rx_trunc    = 1'b0;
        end else begin
            case (rx_phase)
                PH_ID: begin
                    rx_id    = it.rx_byte;
                    rx_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (rx_id != cfg_expected_id) begin
                        rx_phase     = PH_FAILED;
                        res.done_res = 1'b1;
                    end else begin
                        if (it.rx_byte > cfg_capacity) begin
                            rx_trunc = 1'b1;
                            rx_len   = cfg_capacity;
                        end else begin
                            rx_len = it.rx_byte;
                        end
                        rx_crc   = crc_ccitt_byte(crc_ccitt_byte(CRC_INIT, rx_id), rx_len);
                        rx_count = 8'd0;
                        rx_phase = (rx_len == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = it.rx_byte;
                    res.payload_index = rx_count;
                    rx_crc   = crc_ccitt_byte(rx_crc, it.rx_byte);
                    rx_count = rx_count + 8'd1;
                    if (rx_count >= rx_len) begin
                        rx_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    rx_sent_crc[7:0] = it.rx_byte;
                    rx_phase         = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    rx_sent_crc[15:8] = it.rx_byte;
                    rx_phase          = (rx_sent_crc == rx_crc) ? PH_IDLE : PH_FAILED;
                    res.done_res      = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (rx_phase == PH_IDLE) begin
            res.status = STATUS_IDLE;
        end else if (rx_phase == PH_FAILED) begin
            res.status = STATUS_FAILED;
        end else begin
            res.status = STATUS_RECEIVING;
        end
        res.truncated = rx_trunc;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ch.ready) begin
                predict_packet_byte(pending_bytes.pop_front());
            end
            if (!in_valid || in_ch.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    in_valid <= 1'b1;
                    in_op    <= pending_bytes[0].op;
                    in_byte  <= pending_bytes[0].rx_byte;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("payload_valid", want.payload_valid, out_ch.payload_valid);
                    check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
                    check_field("payload_index", want.payload_index, out_ch.payload_index);
                    check_field("truncated", want.truncated, out_ch.truncated);
                    check_field("done_res", want.done_res, out_ch.done_res);
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // register write driver
    always @(posedge clk) begin
        t_reg_write w;
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ch.ready) begin
                w = pending_writes.pop_front();
                if (w.index == REG_EXPECTED_ID) begin
                    cfg_expected_id = w.data;
                end else if (w.index == REG_CAPACITY) begin
                    cfg_capacity = w.data;
                end
            end
            if (!cfg_valid || cfg_ch.ready) begin
                if (pending_writes.size() != 0) begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending_writes[0].index;
                    cfg_data  <= pending_writes[0].data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ch.ready) || (out_ch.valid && out_ready)
                || (cfg_valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic op, input logic [7:0] b);
        pending_bytes.push_back('{op: op, rx_byte: b});
        bytes_queued++;
    endtask

    task automatic push_frame(input logic [7:0] id, input logic [7:0] sent_len, input logic bad_crc);
        logic [7:0]  used;
        logic [7:0]  b;
        logic [15:0] crc;
        used = (sent_len > stim_cap) ? stim_cap : sent_len;
        push_byte(OP_START, 8'($urandom));
        push_byte(OP_BYTE, id);
        push_byte(OP_BYTE, sent_len);
        crc = crc_ccitt_byte(crc_ccitt_byte(CRC_INIT, id), used);
        for (int i = 0; i < used; i++) begin
            b   = 8'($urandom);
            crc = crc_ccitt_byte(crc, b);
            push_byte(OP_BYTE, b);
        end
        if (bad_crc) begin
            crc = crc ^ (16'd1 << $urandom_range(15));
        end
        push_byte(OP_BYTE, crc[7:0]);
        push_byte(OP_BYTE, crc[15:8]);
    endtask

    task automatic push_random_sequence();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  id;
        logic [7:0]  sent;
        pick = $urandom_range(99);
        if (pick < 70) begin
            id   = ($urandom_range(9) == 0) ? 8'($urandom) : stim_id;
            sent = (stim_cap <= 8'd16 && $urandom_range(3) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(12));
            push_frame(id, sent, $urandom_range(6) == 0);
        end else if (pick < 85) begin
            // frame cut short, abandoned by a later start byte
            sent = 8'($urandom_range(1, 8));
            push_byte(OP_START, 8'($urandom));
            push_byte(OP_BYTE, stim_id);
            push_byte(OP_BYTE, sent);
            n = $urandom_range(sent);
            for (int i = 0; i < n; i++) begin
                push_byte(OP_BYTE, 8'($urandom));
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                push_byte(1'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_registers(input logic [7:0] id, input logic [7:0] cap);
        pending_writes.push_back('{index: REG_EXPECTED_ID, data: id});
        pending_writes.push_back('{index: REG_CAPACITY, data: cap});
        while (pending_writes.size() != 0 || cfg_valid) begin
            @(negedge clk);
        end
        stim_id  = id;
        stim_cap = cap;
    endtask

    initial begin
        int unsigned phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, no idling
        push_byte(OP_BYTE, 8'h00);
        push_frame(8'h00, 8'd0, 1'b0);
        push_frame(8'h00, 8'd2, 1'b1);
        push_byte(OP_START, 8'hFF);
        push_byte(OP_BYTE, 8'hFF);
        push_byte(OP_BYTE, 8'h01);
        push_byte(OP_BYTE, 8'hFF);
        push_byte(OP_START, 8'h00);
        push_byte(OP_BYTE, 8'h00);
        push_byte(OP_BYTE, 8'h03);
        push_byte(OP_BYTE, 8'hA5);
        push_frame(8'h00, 8'd1, 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_registers(8'hFF, 8'd0);
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_registers(8'($urandom), 8'd5);
                    gap_pct   = 88;
                    stall_pct = 0;
                end
                2: begin
                    write_registers(8'h00, 8'd255);
                    gap_pct   = 0;
                    stall_pct = 88;
                    push_frame(8'h00, 8'd255, 1'b0);
                end
                default: begin
                    write_registers(8'($urandom), 8'($urandom_range(1, 12)));
                    gap_pct   = 32;
                    stall_pct = 32;
                end
            endcase
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 50) begin
                push_random_sequence();
            end
            wait_drained();
        end

        repeat (4) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ccpr_pkg.sv
hdl/ccpr_if.sv
hdl/crc_checked_packet_receiver_top.sv
tb/tb_top.sv
